FILE: design/stencil_3x3_weighted_filter_defines.svh
// ---------------------------------------------------------------------------
// Stencil filter assertion macros
// Shared concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef STENCIL_3X3_WEIGHTED_FILTER_DEFINES_SVH
`define STENCIL_3X3_WEIGHTED_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define STF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define STF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define STF_ASSERT(lbl, prop, msg)
`define STF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/stf_pkg.sv
// ---------------------------------------------------------------------------
// Stencil filter package
// Sizes, register indexes, shared types and the register clamp function.
// ---------------------------------------------------------------------------
package stf_pkg;

    // Longest supported image row; sets the depth of the line memory.
    localparam int MAX_WIDTH    = 512;
    localparam int HEIGHT_LIMIT = 512;
    localparam int MIN_SIZE     = 3;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 10;
    localparam int VALUE_W = 13;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int CNT_W   = (ADDR_W > CFG_W) ? ADDR_W : CFG_W;
    localparam int LINE_W  = 2 * PIX_W;

    // Configuration register indexes.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Input command codes.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] t_pixel;

    // Control for the window cells: shift in a new column, or clear all.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctrl;

    // Clamp a written value into [MIN_SIZE, hi].
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CNT_W:0] hi);
        logic [CNT_W:0] ext;
        ext = (CNT_W+1)'(v);
        if (ext < (CNT_W+1)'(MIN_SIZE)) begin
            return CFG_W'(MIN_SIZE);
        end else if (ext > hi) begin
            return CFG_W'(hi);
        end
        return v;
    endfunction

    localparam logic [CFG_W-1:0] WIDTH_RESET  =
        CFG_W'((MAX_WIDTH < 512) ? MAX_WIDTH : 512);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(512);

endpackage

FILE: design/stf_line_mem.sv
// ---------------------------------------------------------------------------
// Stencil filter line memory
// Holds the upper and middle image rows side by side, one word per column.
// ---------------------------------------------------------------------------
module stf_line_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [stf_pkg::ADDR_W-1:0] i_waddr,
    input  logic [stf_pkg::LINE_W-1:0] i_wdata,
    input  logic [stf_pkg::ADDR_W-1:0] i_raddr,
    output logic [stf_pkg::LINE_W-1:0] o_rdata
);
    import stf_pkg::*;

    logic [LINE_W-1:0] r_mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/stf_cell.sv
// ---------------------------------------------------------------------------
// Stencil filter window cell
// One pixel of the 3x3 window; loads its neighbor on every shift.
// ---------------------------------------------------------------------------
module stf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stf_pkg::t_win_ctrl i_ctrl,
    input  stf_pkg::t_pixel    i_d,
    output stf_pkg::t_pixel    o_q
);
    import stf_pkg::*;

    t_pixel r_q;

    // Clear on reset or frame restart, otherwise take the neighbor on shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_q <= '0;
        end else if (i_ctrl.shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

FILE: design/stf_window.sv
// ---------------------------------------------------------------------------
// Stencil filter window
// Three rows of three cells plus the weighted sum in half units.
// ---------------------------------------------------------------------------
module stf_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stf_pkg::t_win_ctrl          i_ctrl,
    input  stf_pkg::t_pixel             i_top,
    input  stf_pkg::t_pixel             i_mid,
    input  stf_pkg::t_pixel             i_new,
    input  logic                        i_border,
    output logic [stf_pkg::VALUE_W-1:0] o_value
);
    import stf_pkg::*;

    t_pixel w_q   [3][3];
    t_pixel w_src [3];

    logic [PIX_W+2:0]   w_ring;
    logic [PIX_W+3:0]   w_centre10;
    logic [VALUE_W-1:0] w_sum;

    assign w_src[0] = i_top;
    assign w_src[1] = i_mid;
    assign w_src[2] = i_new;

    // Each row is a chain: the new column enters at the right end and
    // moves one cell to the left per shift.
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar k = 0; k < 3; k++) begin : g_col
            if (k == 2) begin : g_head
                stf_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (i_ctrl),
                    .i_d     (w_src[r]),
                    .o_q     (w_q[r][k])
                );
            end else begin : g_link
                stf_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (i_ctrl),
                    .i_d     (w_q[r][k+1]),
                    .o_q     (w_q[r][k])
                );
            end
        end
    end

    // Eight neighbors at weight one plus ten times the centre, in half units.
    always_comb begin
        w_ring = (PIX_W+3)'(w_q[0][0]) + (PIX_W+3)'(w_q[0][1])
               + (PIX_W+3)'(w_q[0][2]) + (PIX_W+3)'(w_q[1][0])
               + (PIX_W+3)'(w_q[1][2]) + (PIX_W+3)'(w_q[2][0])
               + (PIX_W+3)'(w_q[2][1]) + (PIX_W+3)'(w_q[2][2]);
        w_centre10 = ((PIX_W+4)'(w_q[1][1]) << 3) + ((PIX_W+4)'(w_q[1][1]) << 1);
        w_sum = VALUE_W'(w_ring) + VALUE_W'(w_centre10);
    end

    // Border pixels pass through, doubled into half units.
    assign o_value = i_border ? (VALUE_W'(w_q[1][1]) << 1) : w_sum;

endmodule

FILE: design/stencil_3x3_weighted_filter.sv
// ---------------------------------------------------------------------------
// 3x3 weighted stencil filter
// Raster-order 8-bit image filter with line memory and a 3x3 window.
// ---------------------------------------------------------------------------
// Usage: pixels enter in raster order on i_valid/o_stall with i_cmd at pixel.
// After the last pixel of a frame, send flush items (or more pixels, whose
// values are discarded) to push out the last row; image_width + 1 of them
// end the frame, and the last result carries o_end_of_frame.
// Each result belongs to the pixel one row and one column behind the input.
// Results leave on o_valid/i_stall: value in half units, border flag, and
// end-of-frame flag. Border pixels come out doubled with o_is_border set.
// Throughput is one item per clock while o_stall is low. An accepted item
// that produces a result passes the first stage, then the output stage, to
// o_valid. The line memory is read one column ahead, so its ports touch the
// same column only on the end-of-frame item; no item waits for the memory.
// The two-stage output pipeline keeps taking items while a result waits;
// o_stall rises only once both stages hold a result and i_stall is high.
// Reset sets width and height to 512 and restarts the frame. A register
// write clamps the value to its legal range and also restarts the frame.
// ---------------------------------------------------------------------------
module stencil_3x3_weighted_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_addr,
    input  logic [stf_pkg::CFG_W-1:0]   i_cfg_data,
    // Input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_cmd,
    input  logic [stf_pkg::PIX_W-1:0]   i_pixel,
    // Output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [stf_pkg::VALUE_W-1:0] o_value_half,
    output logic                        o_is_border,
    output logic                        o_end_of_frame
);
    import stf_pkg::*;

    `include "stencil_3x3_weighted_filter_defines.svh"

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [CNT_W-1:0] r_col;
    logic [CFG_W-1:0] r_row;

    logic [CNT_W-1:0] n_col;
    logic [CFG_W-1:0] n_row;

    logic               r_a_valid;
    logic               r_a_border;
    logic               r_a_eof;
    logic               r_b_valid;
    logic [VALUE_W-1:0] r_value;
    logic               r_border;
    logic               r_eof;

    logic [CNT_W-1:0]  w_c;
    logic              w_flushing;
    logic              w_accept;
    logic              w_proc;
    logic              w_adv_b;
    logic              w_last_col;
    logic              w_emit;
    logic              w_border;
    logic              w_eof;
    t_pixel            w_v;
    t_pixel            w_top;
    t_pixel            w_mid;
    logic [LINE_W-1:0] w_rdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [VALUE_W-1:0] w_value;
    t_win_ctrl         w_ctrl;

    // Handshake: the output stage frees when empty or taken.
    assign w_adv_b  = !r_b_valid || !i_stall;
    assign o_stall  = r_a_valid && !w_adv_b;
    assign w_accept = i_valid && !o_stall;

    // Position decode for the current item.
    assign w_c        = (r_col >= CNT_W'(r_width)) ? '0 : r_col;
    assign w_flushing = (r_row >= r_height);
    assign w_proc     = w_accept && !i_cfg_we && (w_flushing || (i_cmd == CMD_PIXEL));
    assign w_v        = w_flushing ? '0 : i_pixel;
    assign w_last_col = ((CNT_W+1)'(w_c) + (CNT_W+1)'(1)) >= (CNT_W+1)'(r_width);

    assign w_emit   = (r_row >= CFG_W'(2)) || ((r_row == CFG_W'(1)) && (w_c != '0));
    assign w_border = (w_c == '0) || (w_c == CNT_W'(1)) ||
                      (r_row == CFG_W'(1)) || (r_row == r_height);
    assign w_eof    = (r_row == (r_height + CFG_W'(1))) && (w_c == '0);

    // Counter advance, wrapping at row end and at frame end.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_proc) begin
            if (w_eof) begin
                n_col = '0;
                n_row = '0;
            end else if (w_last_col) begin
                n_col = '0;
                n_row = r_row + CFG_W'(1);
            end else begin
                n_col = w_c + CNT_W'(1);
            end
        end
    end

    // Configuration registers and frame counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_IMAGE_WIDTH:  r_width  <= clamp_size(i_cfg_data, (CNT_W+1)'(MAX_WIDTH));
                REG_IMAGE_HEIGHT: r_height <= clamp_size(i_cfg_data, (CNT_W+1)'(HEIGHT_LIMIT));
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line memory: read the column the next item will use.
    assign w_top   = w_rdata[LINE_W-1:PIX_W];
    assign w_mid   = w_rdata[PIX_W-1:0];
    assign w_raddr = i_cfg_we ? '0 : (w_proc ? n_col[ADDR_W-1:0] : w_c[ADDR_W-1:0]);

    stf_line_mem u_line_mem (
        .i_clk   (i_clk),
        .i_we    (w_proc),
        .i_waddr (w_c[ADDR_W-1:0]),
        .i_wdata ({w_mid, w_v}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Window of cells and weighted sum.
    assign w_ctrl.shift = w_proc;
    assign w_ctrl.clear = i_cfg_we;

    stf_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_top    (w_top),
        .i_mid    (w_mid),
        .i_new    (w_v),
        .i_border (r_a_border),
        .o_value  (w_value)
    );

    // First stage: flags for the item now held in the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_proc) begin
            r_a_valid <= w_emit;
        end else if (w_adv_b) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_a_border <= w_border;
            r_a_eof    <= w_eof;
        end
    end

    // Output stage: registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_b && r_a_valid) begin
            r_value  <= w_value;
            r_border <= r_a_border;
            r_eof    <= r_a_eof;
        end
    end

    assign o_valid        = r_b_valid;
    assign o_value_half   = r_value;
    assign o_is_border    = r_border;
    assign o_end_of_frame = r_eof;

    // Assertions.
    `STF_ASSERT(a_stall_when_full, (r_a_valid && r_b_valid && i_stall) |-> o_stall, "stall missed")
    `STF_ASSERT(a_col_in_row, r_col < CNT_W'(r_width), "column counter beyond row width")
    `STF_ASSERT(a_row_bound, r_row <= (r_height + CFG_W'(1)), "row counter beyond flush rows")
    `STF_ASSERT(a_eof_is_border, (r_a_valid && r_a_eof) |-> r_a_border, "end of frame off border")
    `STF_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_a_valid && !r_b_valid, "busy after reset")

endmodule
